// ===== design/bmp_rle8_encoder_macros.svh =====
// ----------------------------------------------------------------------------
// bmp_rle8_encoder_macros
// assertion macros used by the checker of the rle8 encoder
// ----------------------------------------------------------------------------
`ifndef BMP_RLE8_ENCODER_MACROS_SVH
`define BMP_RLE8_ENCODER_MACROS_SVH

// same-cycle implication, disabled while in reset
`define BRLE8_ASSERT_IMPL(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("rle8 encoder port check failed");

// next-cycle implication, disabled while in reset
`define BRLE8_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("rle8 encoder port check failed");

`endif

// ===== design/brle8_pkg.sv =====
// ----------------------------------------------------------------------------
// brle8_pkg
// types and constants of the bmp rle8 encoder
// ----------------------------------------------------------------------------
package brle8_pkg;

  localparam logic [7:0]  RUN_CAP         = 8'd255;
  localparam int          MIN_RUN         = 3;
  localparam logic [15:0] ROW_WIDTH_RESET = 16'd256;
  localparam int          Q_DEPTH         = 4;

  typedef struct packed {
    logic [7:0] pixel;
    logic       final_pixel;
  } in_item_t;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       run_last;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_PUSH,
    CMD_FLUSH,
    CMD_PAIR
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t    op;
    logic [7:0] a;
    logic [7:0] b;
    logic       flush;
    logic       last;
  } cmd_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_RUN,
    F_FLUSH,
    F_END
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_PAIR_B,
    B_LHEAD,
    B_LCNT,
    B_DATA,
    B_PAD
  } back_state_t;

endpackage

// ===== design/brle8_ram.sv =====
// ----------------------------------------------------------------------------
// brle8_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module brle8_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 48
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/brle8_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// brle8_cmd_fifo
// short command queue between the run tracker and the byte emitter
// ----------------------------------------------------------------------------
module brle8_cmd_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  brle8_pkg::cmd_t  din,
  input  logic             pop,
  output brle8_pkg::cmd_t  dout,
  output logic             empty,
  output logic             full
);

  localparam int AW = $clog2(brle8_pkg::Q_DEPTH);
  localparam int CW = $clog2(brle8_pkg::Q_DEPTH + 1);

  brle8_pkg::cmd_t mem [brle8_pkg::Q_DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign empty = (count == '0);
  assign full  = (count == CW'(brle8_pkg::Q_DEPTH));
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ===== design/brle8_front.sv =====
// ----------------------------------------------------------------------------
// brle8_front
// run tracker: takes pixels, follows runs, rows and the literal fill level,
// and issues store, flush and pair commands
// ----------------------------------------------------------------------------
module brle8_front #(
  parameter int LIT_MAX = 48
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [15:0]           cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  brle8_pkg::in_item_t   in_item,
  input  logic                  q_full,
  output logic                  q_push,
  output brle8_pkg::cmd_t       q_din
);

  localparam int CW = $clog2(LIT_MAX + 1);

  brle8_pkg::front_state_t state, state_next;

  logic [15:0]   row_width;
  logic [7:0]    run_value;
  logic [7:0]    run_length;
  logic [15:0]   column;
  logic [CW-1:0] lit_cnt;
  logic [7:0]    cur_val;
  logic [7:0]    cur_len;
  logic [1:0]    left;
  logic          phase_b;
  logic          job_end;
  logic          job_fin;
  logic [7:0]    nv;
  logic [7:0]    nl;

  logic          accept;
  logic          extend;
  logic          close_old;
  logic [7:0]    l2;
  logic [15:0]   col_inc;
  logic          endf;
  logic          is_long;
  logic          lit_full;
  logic          close_done;

  assign in_stall  = (state != brle8_pkg::F_IDLE);
  assign accept    = in_valid && (state == brle8_pkg::F_IDLE);
  assign extend    = (run_length != 8'd0) && (in_item.pixel == run_value) &&
                     (run_length != brle8_pkg::RUN_CAP);
  assign close_old = !extend && (run_length != 8'd0);
  assign l2        = extend ? (run_length + 8'd1) : 8'd1;
  assign col_inc   = column + 16'd1;
  assign endf      = in_item.final_pixel || (col_inc == row_width);
  assign is_long   = (cur_len >= 8'(brle8_pkg::MIN_RUN));
  assign lit_full  = (lit_cnt == CW'(LIT_MAX));
  assign close_done = (state == brle8_pkg::F_RUN) && !q_full &&
                      ((is_long && (lit_cnt == '0)) || (!is_long && (left == 2'd1)));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= brle8_pkg::F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_push     = 1'b0;
    q_din      = '0;
    case (state)
      brle8_pkg::F_IDLE: begin
        if (accept && (close_old || endf)) begin
          state_next = brle8_pkg::F_RUN;
        end
      end
      brle8_pkg::F_RUN: begin
        if (!q_full) begin
          q_push = 1'b1;
          if (is_long) begin
            if (lit_cnt != '0) begin
              q_din.op = brle8_pkg::CMD_FLUSH;
            end else begin
              q_din.op   = brle8_pkg::CMD_PAIR;
              q_din.a    = cur_len;
              q_din.b    = cur_val;
              q_din.last = !job_end;
            end
          end else begin
            q_din.op    = brle8_pkg::CMD_PUSH;
            q_din.a     = cur_val;
            q_din.flush = lit_full;
            q_din.last  = !job_end && lit_full;
          end
        end
        if (close_done) begin
          if (phase_b) begin
            state_next = brle8_pkg::F_FLUSH;
          end else if (!job_end) begin
            state_next = brle8_pkg::F_IDLE;
          end
        end
      end
      brle8_pkg::F_FLUSH: begin
        if (lit_cnt == '0) begin
          state_next = brle8_pkg::F_END;
        end else if (!q_full) begin
          q_push     = 1'b1;
          q_din.op   = brle8_pkg::CMD_FLUSH;
          state_next = brle8_pkg::F_END;
        end
      end
      brle8_pkg::F_END: begin
        if (!q_full) begin
          q_push     = 1'b1;
          q_din.op   = brle8_pkg::CMD_PAIR;
          q_din.a    = 8'd0;
          q_din.b    = {7'd0, job_fin};
          q_din.last = 1'b1;
          state_next = brle8_pkg::F_IDLE;
        end
      end
      default: begin
        state_next = brle8_pkg::F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width  <= brle8_pkg::ROW_WIDTH_RESET;
      run_value  <= 8'd0;
      run_length <= 8'd0;
      column     <= 16'd0;
      lit_cnt    <= '0;
      cur_val    <= 8'd0;
      cur_len    <= 8'd0;
      left       <= 2'd0;
      phase_b    <= 1'b0;
      job_end    <= 1'b0;
      job_fin    <= 1'b0;
      nv         <= 8'd0;
      nl         <= 8'd0;
    end else begin
      if (cfg_we) begin
        row_width <= cfg_wdata;
      end
      if (accept) begin
        run_length <= endf ? 8'd0 : l2;
        run_value  <= in_item.final_pixel ? 8'd0 : in_item.pixel;
        column     <= endf ? 16'd0 : col_inc;
        job_end    <= endf;
        job_fin    <= in_item.final_pixel;
        nv         <= in_item.pixel;
        nl         <= l2;
        if (close_old) begin
          cur_val <= run_value;
          cur_len <= run_length;
          left    <= run_length[1:0];
          phase_b <= 1'b0;
        end else begin
          cur_val <= in_item.pixel;
          cur_len <= l2;
          left    <= l2[1:0];
          phase_b <= 1'b1;
        end
      end
      // old run closed on a row or image end: close the new run next
      if (close_done && !phase_b && job_end) begin
        cur_val <= nv;
        cur_len <= nl;
        left    <= nl[1:0];
        phase_b <= 1'b1;
      end else if (q_push && (q_din.op == brle8_pkg::CMD_PUSH)) begin
        left <= left - 2'd1;
      end
      if (q_push) begin
        case (q_din.op)
          brle8_pkg::CMD_FLUSH: lit_cnt <= '0;
          brle8_pkg::CMD_PUSH:  lit_cnt <= q_din.flush ? CW'(1) : (lit_cnt + CW'(1));
          default:              lit_cnt <= lit_cnt;
        endcase
      end
    end
  end

endmodule

// ===== design/brle8_back.sv =====
// ----------------------------------------------------------------------------
// brle8_back
// byte emitter: holds the literal store and turns commands into code bytes
// ----------------------------------------------------------------------------
module brle8_back #(
  parameter int LIT_MAX = 48
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_empty,
  input  brle8_pkg::cmd_t       q_dout,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output brle8_pkg::out_item_t  out_item
);

  localparam int CW = $clog2(LIT_MAX + 1);
  localparam int AW = $clog2(LIT_MAX);

  brle8_pkg::back_state_t state, state_next;

  logic [CW-1:0]   cnt, cnt_next;
  logic [AW-1:0]   idx, idx_next;
  brle8_pkg::cmd_t cur;

  logic            out_free;
  logic            emit;
  logic [7:0]      emit_byte;
  logic            emit_last;
  logic            done;
  logic            is_long;
  logic            final_byte;
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [7:0]      ram_wdata;
  logic [7:0]      ram_rdata;

  assign out_free   = !out_valid || !out_stall;
  assign is_long    = (cnt >= CW'(brle8_pkg::MIN_RUN));
  assign final_byte = ((CW'(idx) + CW'(1)) == cnt);

  brle8_ram #(
    .WIDTH (8),
    .DEPTH (LIT_MAX)
  ) u_lit_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx_next),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= brle8_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    emit       = 1'b0;
    emit_byte  = 8'd0;
    emit_last  = 1'b0;
    done       = 1'b0;
    idx_next   = idx;
    cnt_next   = cnt;
    ram_we     = 1'b0;
    ram_waddr  = cnt[AW-1:0];
    ram_wdata  = q_dout.a;
    case (state)
      brle8_pkg::B_IDLE: begin
        if (!q_empty) begin
          case (q_dout.op)
            brle8_pkg::CMD_PUSH: begin
              q_pop = 1'b1;
              if (q_dout.flush) begin
                state_next = brle8_pkg::B_LHEAD;
              end else begin
                ram_we   = 1'b1;
                cnt_next = cnt + CW'(1);
              end
            end
            brle8_pkg::CMD_FLUSH: begin
              q_pop      = 1'b1;
              state_next = brle8_pkg::B_LHEAD;
            end
            brle8_pkg::CMD_PAIR: begin
              if (out_free) begin
                q_pop      = 1'b1;
                emit       = 1'b1;
                emit_byte  = q_dout.a;
                state_next = brle8_pkg::B_PAIR_B;
              end
            end
            default: begin
              q_pop = 1'b1;
            end
          endcase
        end
      end
      brle8_pkg::B_PAIR_B: begin
        if (out_free) begin
          emit       = 1'b1;
          emit_byte  = cur.b;
          emit_last  = cur.last;
          state_next = brle8_pkg::B_IDLE;
        end
      end
      brle8_pkg::B_LHEAD: begin
        if (out_free) begin
          emit       = 1'b1;
          emit_byte  = is_long ? 8'd0 : 8'd1;
          state_next = is_long ? brle8_pkg::B_LCNT : brle8_pkg::B_DATA;
        end
      end
      brle8_pkg::B_LCNT: begin
        if (out_free) begin
          emit       = 1'b1;
          emit_byte  = 8'(cnt);
          state_next = brle8_pkg::B_DATA;
        end
      end
      brle8_pkg::B_DATA: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_byte = ram_rdata;
          emit_last = cur.last && final_byte && !(is_long && cnt[0]);
          if (final_byte) begin
            if (is_long && cnt[0]) begin
              state_next = brle8_pkg::B_PAD;
            end else begin
              done = 1'b1;
            end
          end else begin
            idx_next   = idx + AW'(1);
            state_next = is_long ? brle8_pkg::B_DATA : brle8_pkg::B_LHEAD;
          end
        end
      end
      brle8_pkg::B_PAD: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_byte = 8'd0;
          emit_last = cur.last;
          done      = 1'b1;
        end
      end
      default: begin
        state_next = brle8_pkg::B_IDLE;
      end
    endcase
    // flush finished: empty the store, then place a pending byte first
    if (done) begin
      idx_next   = '0;
      state_next = brle8_pkg::B_IDLE;
      if (cur.op == brle8_pkg::CMD_PUSH) begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = cur.a;
        cnt_next  = CW'(1);
      end else begin
        cnt_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      cnt <= cnt_next;
      idx <= idx_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_dout;
    end
    if (emit) begin
      out_item.code_byte <= emit_byte;
      out_item.run_last  <= emit_last;
    end
  end

endmodule

// ===== design/bmp_rle8_encoder.sv =====
// a pixel that only extends a run leaves the run tracker ready for the next pixel; while the
// tracker issues commands, in_stall holds the input; a literal block of n bytes goes out as
// a 00 escape, the count, the bytes and a 00 pad for odd n, one or two leftovers as a 01 byte
// and the pixel each; the 4-entry queue sets back-pressure
// reset (synchronous): runs, column, literal count and queue clear, row_width is 256;
// the literal store itself is not cleared
// ----------------------------------------------------------------------------
// bmp_rle8_encoder
// pixel stream to bmp rle8 code bytes, run tracker and byte emitter joined
// by a short command queue
// ----------------------------------------------------------------------------
module bmp_rle8_encoder #(
  parameter int LIT_MAX = 48
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [15:0]           cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  brle8_pkg::in_item_t   in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output brle8_pkg::out_item_t  out_item
);

  logic            q_push;
  logic            q_pop;
  logic            q_empty;
  logic            q_full;
  brle8_pkg::cmd_t q_din;
  brle8_pkg::cmd_t q_dout;

  brle8_front #(
    .LIT_MAX (LIT_MAX)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_din     (q_din)
  );

  brle8_cmd_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty),
    .full  (q_full)
  );

  brle8_back #(
    .LIT_MAX (LIT_MAX)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_dout    (q_dout),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

// ===== design/brle8_checker.sv =====
// ----------------------------------------------------------------------------
// brle8_checker
// port-level checks of the rle8 encoder, bound to the top level
// ----------------------------------------------------------------------------
`include "bmp_rle8_encoder_macros.svh"

module brle8_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input brle8_pkg::out_item_t  out_item
);

  // a stalled byte stays offered and unchanged
  `BRLE8_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_item))

  // no byte is offered right after reset
  `BRLE8_ASSERT_IMPL(a_out_quiet, clk, rst, $past(rst), !out_valid)

  // the encoder takes pixels right after reset
  `BRLE8_ASSERT_IMPL(a_in_ready, clk, rst, $past(rst), !in_stall)

endmodule

bind bmp_rle8_encoder brle8_checker u_chk (.*);

// ===== tb/bmp_rle8_encoder_tb.sv =====
// ----------------------------------------------------------------------------
// bmp_rle8_encoder_tb
// drives pixels through the rle8 encoder under random idling and stalls and
// checks every code byte and its last flag against a cycle-free model of the
// encoding rules, over several row widths including the extremes
// ----------------------------------------------------------------------------
module bmp_rle8_encoder_tb;

  localparam int LIT_MAX      = 48;
  localparam int RESULT_LIMIT = 59;
  localparam int SHOW_MAX     = 100;

  class rle8_code_tracker;
    logic [15:0] row_width;
    logic [7:0]  lit_store [LIT_MAX];
    int unsigned lit_count;
    int unsigned run_len;
    logic [7:0]  run_val;
    logic [15:0] column;
    logic [7:0]  step_bytes [$];
    brle8_pkg::out_item_t code_q [$];
    int unsigned errors;
    int unsigned pixels;
    int unsigned bytes_seen;
    int unsigned cap_closes;
    int unsigned full_flushes;

    function new();
      row_width    = brle8_pkg::ROW_WIDTH_RESET;
      lit_count    = 0;
      run_len      = 0;
      run_val      = '0;
      column       = '0;
      errors       = 0;
      pixels       = 0;
      bytes_seen   = 0;
      cap_closes   = 0;
      full_flushes = 0;
    endfunction

    function void put_byte(logic [7:0] b);
      if (step_bytes.size() < RESULT_LIMIT) step_bytes.push_back(b);
    endfunction

    function void flush_literals();
      if (lit_count >= brle8_pkg::MIN_RUN) begin
        put_byte(8'd0);
        put_byte(8'(lit_count));
        for (int k = 0; k < lit_count; k++) put_byte(lit_store[k]);
        if (lit_count % 2) put_byte(8'd0);
      end else begin
        for (int k = 0; k < lit_count; k++) begin
          put_byte(8'd1);
          put_byte(lit_store[k]);
        end
      end
      lit_count = 0;
    endfunction

    function void push_literal(logic [7:0] b);
      if (lit_count >= LIT_MAX) begin
        full_flushes++;
        flush_literals();
      end
      lit_store[lit_count] = b;
      lit_count++;
    endfunction

    function void close_run();
      if (run_len >= brle8_pkg::MIN_RUN) begin
        flush_literals();
        put_byte(8'(run_len));
        put_byte(run_val);
      end else begin
        for (int k = 0; k < run_len; k++) push_literal(run_val);
      end
      run_len = 0;
    endfunction

    // note one accepted pixel and queue the code bytes it causes
    function void take_pixel(brle8_pkg::in_item_t it);
      brle8_pkg::out_item_t o;
      step_bytes.delete();
      pixels++;
      if (run_len > 0 && it.pixel == run_val && run_len < brle8_pkg::RUN_CAP) begin
        run_len++;
      end else begin
        if (run_len == brle8_pkg::RUN_CAP && it.pixel == run_val) cap_closes++;
        close_run();
        run_val = it.pixel;
        run_len = 1;
      end
      column = column + 16'd1;
      if (it.final_pixel) begin
        close_run();
        flush_literals();
        put_byte(8'd0);
        put_byte(8'd1);
        column  = '0;
        run_val = '0;
      end else if (column == row_width) begin
        close_run();
        flush_literals();
        put_byte(8'd0);
        put_byte(8'd0);
        column = '0;
      end
      foreach (step_bytes[i]) begin
        o.code_byte = step_bytes[i];
        o.run_last  = (i == step_bytes.size() - 1);
        code_q.push_back(o);
      end
    endfunction

    // compare one accepted code byte with the oldest one waiting
    function void match_byte(brle8_pkg::out_item_t got);
      brle8_pkg::out_item_t want;
      bytes_seen++;
      if (code_q.size() == 0) begin
        errors++;
        if (errors <= SHOW_MAX)
          $display("%0t: code byte expected none, got %02h last %0b",
                   $time, got.code_byte, got.run_last);
        return;
      end
      want = code_q.pop_front();
      if (got.code_byte !== want.code_byte) begin
        errors++;
        if (errors <= SHOW_MAX)
          $display("%0t: code_byte expected %02h, got %02h",
                   $time, want.code_byte, got.code_byte);
      end
      if (got.run_last !== want.run_last) begin
        errors++;
        if (errors <= SHOW_MAX)
          $display("%0t: run_last expected %0b, got %0b (byte %02h)",
                   $time, want.run_last, got.run_last, want.code_byte);
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [15:0]          cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  brle8_pkg::in_item_t  in_item = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  brle8_pkg::out_item_t out_item;

  logic        calm = 1'b0;
  logic        hold_req = 1'b0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  int          widths_used = 0;

  rle8_code_tracker board = new();

  bmp_rle8_encoder #(
    .LIT_MAX(LIT_MAX)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // receiver: random stalls, one long counted hold-off on request
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && !out_stall) board.match_byte(out_item);
    if (hold_req && !hold_done) begin
      hold_left = 150;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 16);
    end
  end

  task automatic send_pixel(input logic [7:0] px, input logic fin);
    brle8_pkg::in_item_t it;
    it.pixel       = px;
    it.final_pixel = fin;
    while (!calm && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.take_pixel(it);
  endtask

  task automatic send_run(input logic [7:0] px, input int len, input logic fin_end);
    for (int k = 0; k < len; k++) send_pixel(px, fin_end && k == len - 1);
  endtask

  function automatic logic [7:0] pick_pixel();
    case ($urandom_range(9))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // runs of mixed lengths with an occasional stray final pixel
  task automatic send_mixed(input int n, input bit end_final);
    int i;
    int len;
    logic [7:0] v;
    i = 0;
    while (i < n) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4: len = $urandom_range(1, 2);
        5, 6, 7, 8:    len = $urandom_range(3, 9);
        default:       len = $urandom_range(10, 40);
      endcase
      v = pick_pixel();
      repeat (len) begin
        if (i < n) begin
          send_pixel(v, (end_final && i == n - 1) || $urandom_range(99) < 2);
          i++;
        end
      end
    end
  endtask

  // runs of one or two pixels only, so every pixel lands in the literal store
  task automatic send_literals(input int n);
    int i;
    int len;
    logic [7:0] v;
    logic [7:0] nv;
    i = 0;
    v = 8'($urandom_range(255));
    while (i < n) begin
      do nv = 8'($urandom_range(255)); while (nv == v);
      v   = nv;
      len = $urandom_range(1, 2);
      repeat (len) begin
        if (i < n) begin
          send_pixel(v, 1'b0);
          i++;
        end
      end
    end
  endtask

  task automatic settle();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (board.code_q.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (16) @(posedge clk);
  endtask

  task automatic set_width(input logic [15:0] w);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.row_width = w;
    widths_used++;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // default width: encoded run, odd absolute block, short leftover
    send_run(8'h00, 3, 1'b0);
    send_run(8'hff, 2, 1'b0);
    send_pixel(8'h01, 1'b0);
    send_pixel(8'h55, 1'b0);
    send_pixel(8'haa, 1'b0);
    send_run(8'h07, 4, 1'b0);
    send_pixel(8'h09, 1'b1);

    // one pixel per row, final pixel also ends a row
    set_width(16'd1);
    send_pixel(8'hff, 1'b0);
    send_pixel(8'h00, 1'b0);
    send_pixel(8'h80, 1'b1);

    set_width(16'd4);
    send_run(8'h05, 4, 1'b0);
    send_pixel(8'h01, 1'b0);
    send_pixel(8'h02, 1'b0);
    send_pixel(8'h03, 1'b0);
    send_pixel(8'h04, 1'b0);
    send_run(8'h06, 2, 1'b0);
    send_pixel(8'h08, 1'b1);

    // widest row: run past the cap, literal store overflow
    set_width(16'hffff);
    send_mixed(6, 1'b0);
    send_run(pick_pixel(), 255 + $urandom_range(1, 3), 1'b0);
    send_literals($urandom_range(49, 60));
    send_mixed(10, 1'b1);

    // width zero wraps at 16 bits; no idling on either side here
    set_width(16'h0000);
    calm <= 1'b1;
    send_mixed(25, 1'b1);
    calm <= 1'b0;

    // narrow rows with the receiver held off so the encoder backs up
    set_width(16'($urandom_range(2, 12)));
    hold_req <= 1'b1;
    send_mixed(40, 1'b1);

    // width lowered below the column of an open row
    set_width(16'd300);
    send_mixed(25, 1'b0);
    set_width(16'd3);
    send_mixed(20, 1'b1);

    settle();
    if (board.code_q.size() != 0) begin
      board.errors++;
      $display("%0t: code byte expected %02h, got none (%0d left)",
               $time, board.code_q[0].code_byte, board.code_q.size());
    end
    $display("run covered %0d pixels and %0d code bytes over %0d width writes",
             board.pixels, board.bytes_seen, widths_used);
    $display("runs closed at the cap: %0d, full literal store flushes: %0d",
             board.cap_closes, board.full_flushes);
    if (board.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("status: fail");
    $finish;
  end

endmodule
